>>> sv/dbph_pkg.sv
package dbph_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int BANK_COUNT = 2;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int SLOT_AW = $clog2(TABLE_DEPTH * BANK_COUNT);
    localparam int SLOTS = TABLE_DEPTH * BANK_COUNT;
    localparam logic [3:0] LOG2_MAX = 4'(IDX_W);

    localparam logic [63:0] MIX_C1 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C2 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_C = 64'hff51afd7ed558ccd;

    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_INS_CUR = 3'd1;
    localparam logic [2:0] CMD_INS_NEXT = 3'd2;
    localparam logic [2:0] CMD_REMOVE = 3'd3;
    localparam logic [2:0] CMD_STALE = 3'd4;
    localparam logic [2:0] CMD_ADVANCE = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int FL_OCC = 0;
    localparam int FL_DEL = 1;
    localparam int FL_CARRY = 2;
    localparam int FL_STAY = 3;

    typedef struct packed {
        logic [7:0]  probe_dist;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [31:0] word;
        logic        fresh;
    } slot_entry_t;

endpackage

>>> sv/dbph_ram.sv
module dbph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/double_buffered_probe_hash_table_top.sv
// Sequence: the key is hashed, then each probed slot gets a memory read, then an
// evaluate and write back, and finally the result is queued; a remove that unchains
// its predecessor also rewrites that slot's flags first. Advance clears the flags of
// each slot in use, then swaps banks. One transaction is processed at a time; the next
// is taken once the result is queued. Reset is asynchronous; afterwards a pass over
// all 512 slots clears the flag memory while in_stall is held high.
module double_buffered_probe_hash_table_top import dbph_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [31:0] key_x,
    input  logic signed [31:0] key_y,
    input  logic signed [31:0] key_z,
    input  logic [31:0]        payload_word,
    input  logic               payload_fresh,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [1:0]         status,
    output logic [7:0]         slot_index,
    output logic [31:0]        read_word,
    output logic               read_fresh
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HASH, S_RD, S_EV, S_FIXPREV, S_ADV, S_OUT
    } state_t;

    localparam int DATA_W = $bits(slot_entry_t);

    state_t state_reg, state_next;
    logic [3:0] cfg_reg, cfg_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [31:0] kx_reg, kx_next, ky_reg, ky_next, kz_reg, kz_next;
    logic [31:0] word_reg, word_next;
    logic fresh_reg, fresh_next;
    logic [63:0] h_reg, h_next, acc_reg, acc_next;
    logic [2:0] step_reg, step_next;
    logic [IDX_W-1:0] i_reg, i_next, start_reg, start_next, prev_reg, prev_next;
    logic [7:0] dist_reg, dist_next;
    logic have_prev_reg, have_prev_next;
    logic [3:0] prev_flags_reg, prev_flags_next;
    logic bank_reg, bank_next;
    logic [SLOT_AW-1:0] clr_reg, clr_next;
    logic res_hit_reg, res_hit_next, res_fresh_reg, res_fresh_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic [31:0] res_word_reg, res_word_next;
    logic out_valid_reg, out_valid_next, hit_reg, hit_next, fresh_out_reg, fresh_out_next;
    logic [1:0] status_reg, status_next;
    logic [7:0] slot_reg, slot_next;
    logic [31:0] rword_reg, rword_next;

    logic f_we, d_we;
    logic [SLOT_AW-1:0] f_addr, d_addr;
    logic [3:0] f_wd, f_rd;
    logic [DATA_W-1:0] d_wd, d_rd;
    slot_entry_t e, e_new;

    logic [3:0] log2_used;
    logic [IDX_W-1:0] mask;
    logic [31:0] mop_a, mop_b;
    logic [63:0] prod;
    logic bank_sel, key_eq, dist_eq, wrap, is_ins;
    logic [IDX_W-1:0] i_inc;
    logic [3:0] stay;

    dbph_ram #(.WIDTH(4), .DEPTH(SLOTS)) u_flags (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd)
    );

    dbph_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd)
    );

    always_comb
    begin
        if (cfg_reg == 4'd0)
        begin
            log2_used = 4'd1;
        end
        else if (cfg_reg > LOG2_MAX)
        begin
            log2_used = LOG2_MAX;
        end
        else
        begin
            log2_used = cfg_reg;
        end
    end

    assign mask = IDX_W'((9'd1 << log2_used) - 9'd1);
    assign e = slot_entry_t'(d_rd);
    assign bank_sel = (cmd_reg == CMD_INS_NEXT) ? ~bank_reg : bank_reg;
    assign key_eq = (e.kx == kx_reg) && (e.ky == ky_reg) && (e.kz == kz_reg);
    assign dist_eq = (e.probe_dist == dist_reg);
    assign i_inc = (i_reg + 1'b1) & mask;
    assign wrap = (i_inc == start_reg);
    assign is_ins = (cmd_reg == CMD_INS_CUR) || (cmd_reg == CMD_INS_NEXT);
    assign stay = (cmd_reg == CMD_INS_NEXT) ? 4'(1 << FL_STAY) : 4'd0;

    always_comb
    begin
        unique case (step_reg)
            3'd4:
            begin
                mop_a = h_reg[31:0];
                mop_b = MUL_C[63:32];
            end
            3'd5:
            begin
                mop_a = h_reg[63:32];
                mop_b = MUL_C[31:0];
            end
            default:
            begin
                mop_a = h_reg[31:0];
                mop_b = MUL_C[31:0];
            end
        endcase
    end

    assign prod = {32'd0, mop_a} * {32'd0, mop_b};

    always_comb
    begin
        state_next = state_reg;
        cfg_next = cfg_we ? cfg_wdata : cfg_reg;
        cmd_next = cmd_reg;
        kx_next = kx_reg;
        ky_next = ky_reg;
        kz_next = kz_reg;
        word_next = word_reg;
        fresh_next = fresh_reg;
        h_next = h_reg;
        acc_next = acc_reg;
        step_next = step_reg;
        i_next = i_reg;
        start_next = start_reg;
        prev_next = prev_reg;
        dist_next = dist_reg;
        have_prev_next = have_prev_reg;
        prev_flags_next = prev_flags_reg;
        bank_next = bank_reg;
        clr_next = clr_reg;
        res_hit_next = res_hit_reg;
        res_fresh_next = res_fresh_reg;
        res_status_next = res_status_reg;
        res_slot_next = res_slot_reg;
        res_word_next = res_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        hit_next = hit_reg;
        fresh_out_next = fresh_out_reg;
        status_next = status_reg;
        slot_next = slot_reg;
        rword_next = rword_reg;
        f_we = 1'b0;
        d_we = 1'b0;
        f_addr = {bank_sel, i_reg};
        d_addr = {bank_sel, i_reg};
        f_wd = 4'd0;
        e_new = e;
        in_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_CLEAR:
            begin
                f_we = 1'b1;
                f_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_AW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = command;
                    kx_next = key_x;
                    ky_next = key_y;
                    kz_next = key_z;
                    word_next = payload_word;
                    fresh_next = payload_fresh;
                    h_next = {{32{key_x[31]}}, key_x};
                    step_next = 3'd0;
                    clr_next = '0;
                    res_hit_next = 1'b0;
                    res_fresh_next = 1'b0;
                    res_status_next = ST_OK;
                    res_slot_next = '0;
                    res_word_next = '0;
                    if (command == CMD_ADVANCE)
                    begin
                        state_next = S_ADV;
                    end
                    else if (command > CMD_ADVANCE)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    3'd0: h_next = h_reg ^ ({{32{ky_reg[31]}}, ky_reg} + MIX_C1
                                   + (h_reg << 6) + (h_reg >> 2));
                    3'd1: h_next = h_reg ^ ({{32{kz_reg[31]}}, kz_reg} + MIX_C2
                                   + (h_reg << 6) + (h_reg >> 2));
                    3'd2: h_next = h_reg ^ (h_reg >> 33);
                    3'd3: acc_next = prod;
                    3'd4, 3'd5: acc_next = acc_reg + {prod[31:0], 32'd0};
                    default:
                    begin
                        i_next = (acc_reg[IDX_W-1:0] ^ acc_reg[33 +: IDX_W]) & mask;
                        start_next = (acc_reg[IDX_W-1:0] ^ acc_reg[33 +: IDX_W]) & mask;
                        dist_next = 8'd0;
                        have_prev_next = 1'b0;
                        state_next = S_RD;
                    end
                endcase
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                state_next = S_OUT;
                e_new.probe_dist = dist_reg;
                e_new.kx = kx_reg;
                e_new.ky = ky_reg;
                e_new.kz = kz_reg;
                e_new.word = word_reg;
                e_new.fresh = fresh_reg;
                if (is_ins)
                begin
                    res_hit_next = 1'b1;
                    res_slot_next = i_reg;
                    if (f_rd[FL_DEL])
                    begin
                        f_we = 1'b1;
                        d_we = 1'b1;
                        f_wd = 4'(1 << FL_OCC) | stay;
                    end
                    else if (f_rd[FL_OCC])
                    begin
                        f_we = 1'b1;
                        f_wd = f_rd | (dist_eq ? 4'(1 << FL_CARRY) : 4'd0);
                        if (key_eq)
                        begin
                            f_wd = f_rd | (dist_eq ? 4'(1 << FL_CARRY) : 4'd0) | stay;
                            d_we = 1'b1;
                            e_new.probe_dist = e.probe_dist;
                        end
                        else if (wrap)
                        begin
                            res_hit_next = 1'b0;
                            res_slot_next = '0;
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            i_next = i_inc;
                            dist_next = dist_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        f_we = 1'b1;
                        d_we = 1'b1;
                        f_wd = f_rd | 4'(1 << FL_OCC) | stay;
                    end
                end
                else
                begin
                    res_status_next = ST_MISS;
                    e_new = e;
                    if (f_rd[FL_OCC] || f_rd[FL_DEL])
                    begin
                        if (f_rd[FL_OCC] && !f_rd[FL_DEL] && dist_eq && key_eq)
                        begin
                            res_status_next = ST_OK;
                            res_hit_next = 1'b1;
                            res_slot_next = i_reg;
                            if (cmd_reg == CMD_LOOKUP)
                            begin
                                res_word_next = e.word;
                                res_fresh_next = e.fresh;
                            end
                            else if (cmd_reg == CMD_STALE)
                            begin
                                e_new.fresh = 1'b0;
                                d_we = 1'b1;
                            end
                            else
                            begin
                                f_we = 1'b1;
                                f_wd = f_rd | 4'(1 << FL_DEL);
                                if (!f_rd[FL_CARRY] && have_prev_reg)
                                begin
                                    state_next = S_FIXPREV;
                                end
                            end
                        end
                        else if (f_rd[FL_OCC] && !f_rd[FL_DEL] && dist_eq
                                 && !f_rd[FL_CARRY])
                        begin
                            res_status_next = ST_MISS;
                        end
                        else if (!wrap)
                        begin
                            if (f_rd[FL_OCC] && !f_rd[FL_DEL] && dist_eq)
                            begin
                                have_prev_next = 1'b1;
                                prev_next = i_reg;
                                prev_flags_next = f_rd;
                            end
                            i_next = i_inc;
                            dist_next = dist_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_FIXPREV:
            begin
                f_we = 1'b1;
                f_addr = {bank_reg, prev_reg};
                f_wd = prev_flags_reg & ~4'(1 << FL_CARRY);
                state_next = S_OUT;
            end
            S_ADV:
            begin
                f_we = 1'b1;
                f_addr = {bank_reg, clr_reg[IDX_W-1:0]};
                clr_next = clr_reg + 1'b1;
                if (clr_reg[IDX_W-1:0] == mask)
                begin
                    bank_next = ~bank_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    hit_next = res_hit_reg;
                    status_next = res_status_reg;
                    slot_next = 8'(res_slot_reg);
                    rword_next = res_word_reg;
                    fresh_out_next = res_fresh_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg != S_CLEAR)
        begin
            d_addr = f_addr;
        end
        d_wd = DATA_W'(e_new);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cfg_reg <= 4'd8;
            bank_reg <= 1'b0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            cmd_reg <= CMD_LOOKUP;
            step_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg <= cfg_next;
            bank_reg <= bank_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
            cmd_reg <= cmd_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kx_reg <= kx_next;
        ky_reg <= ky_next;
        kz_reg <= kz_next;
        word_reg <= word_next;
        fresh_reg <= fresh_next;
        h_reg <= h_next;
        acc_reg <= acc_next;
        i_reg <= i_next;
        start_reg <= start_next;
        prev_reg <= prev_next;
        dist_reg <= dist_next;
        have_prev_reg <= have_prev_next;
        prev_flags_reg <= prev_flags_next;
        res_hit_reg <= res_hit_next;
        res_fresh_reg <= res_fresh_next;
        res_status_reg <= res_status_next;
        res_slot_reg <= res_slot_next;
        res_word_reg <= res_word_next;
        hit_reg <= hit_next;
        fresh_out_reg <= fresh_out_next;
        status_reg <= status_next;
        slot_reg <= slot_next;
        rword_reg <= rword_next;
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign status = status_reg;
    assign slot_index = slot_reg;
    assign read_word = rword_reg;
    assign read_fresh = fresh_out_reg;

endmodule

>>> sv/dbph_checker.sv
module dbph_checker import dbph_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        hit,
    input logic [1:0]  status,
    input logic [7:0]  slot_index,
    input logic [31:0] read_word,
    input logic        read_fresh
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_index))
        else $error("Stalled transaction was dropped or changed.");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !hit && slot_index == 8'd0)
        else $error("Failed transaction reports a slot.");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> read_word == 32'd0 && !read_fresh)
        else $error("Read data present without a hit.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_MISS || status == ST_FULL)
        else $error("Unknown status code.");

endmodule

bind double_buffered_probe_hash_table_top dbph_checker u_dbph_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .status(status), .slot_index(slot_index),
    .read_word(read_word), .read_fresh(read_fresh)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dbph_pkg::*;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [31:0] word;
        logic        fresh;
    } request_t;

    typedef struct {
        logic        hit;
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [31:0] rword;
        logic        rfresh;
    } answer_t;

    class hash_table_scoreboard;
        logic [3:0]  flags [SLOTS];
        logic [7:0]  slot_dist [SLOTS];
        logic [31:0] kx [SLOTS];
        logic [31:0] ky [SLOTS];
        logic [31:0] kz [SLOTS];
        logic [31:0] word [SLOTS];
        logic        fresh [SLOTS];
        logic        bank;
        logic [3:0]  size_log2;
        answer_t     pending [$];
        int          errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                flags[i] = '0;
                slot_dist[i] = '0;
                kx[i] = '0;
                ky[i] = '0;
                kz[i] = '0;
                word[i] = '0;
                fresh[i] = 1'b0;
            end
            bank = 1'b0;
            size_log2 = 4'd8;
            errors = 0;
        endfunction

        function int slots_in_use();
            int l;
            l = size_log2;
            if (l < 1)
                l = 1;
            while (l > 1 && (1 << l) > TABLE_DEPTH)
                l--;
            return 1 << l;
        endfunction

        function int home_of(logic [31:0] x, logic [31:0] y, logic [31:0] z, int size);
            logic [63:0] h;
            h = {{32{x[31]}}, x};
            h ^= {{32{y[31]}}, y} + 64'h9e3779b97f4a7c15 + (h << 6) + (h >> 2);
            h ^= {{32{z[31]}}, z} + 64'hbf58476d1ce4e5b9 + (h << 6) + (h >> 2);
            h ^= h >> 33;
            h = h * 64'hff51afd7ed558ccd;
            h ^= h >> 33;
            return int'(h & 64'(size - 1));
        endfunction

        function bit insert_into(int b, request_t r, output int slot);
            int size;
            int base;
            int i;
            int start;
            int s;
            logic [7:0] d;
            size = slots_in_use();
            base = b * TABLE_DEPTH;
            i = home_of(r.kx, r.ky, r.kz, size);
            start = i;
            d = 0;
            forever
            begin
                s = base + i;
                if (flags[s][FL_DEL] || !flags[s][FL_OCC])
                begin
                    if (flags[s][FL_DEL])
                        flags[s] = 4'b0001;
                    else
                        flags[s][FL_OCC] = 1'b1;
                    kx[s] = r.kx;
                    ky[s] = r.ky;
                    kz[s] = r.kz;
                    word[s] = r.word;
                    fresh[s] = r.fresh;
                    slot_dist[s] = d;
                    slot = i;
                    return 1;
                end
                if (slot_dist[s] == d)
                    flags[s][FL_CARRY] = 1'b1;
                if (kx[s] == r.kx && ky[s] == r.ky && kz[s] == r.kz)
                begin
                    word[s] = r.word;
                    fresh[s] = r.fresh;
                    slot = i;
                    return 1;
                end
                d++;
                i = (i + 1) & (size - 1);
                if (i == start)
                    return 0;
            end
        endfunction

        function bit search(request_t r, bit remove, output int slot);
            int size;
            int base;
            int i;
            int start;
            int s;
            int prev;
            bit have_prev;
            logic [7:0] d;
            logic [3:0] f;
            size = slots_in_use();
            base = bank * TABLE_DEPTH;
            i = home_of(r.kx, r.ky, r.kz, size);
            start = i;
            d = 0;
            have_prev = 0;
            prev = 0;
            slot = 0;
            forever
            begin
                s = base + i;
                f = flags[s];
                if (!f[FL_OCC] && !f[FL_DEL])
                    return 0;
                if (f[FL_OCC] && !f[FL_DEL] && slot_dist[s] == d)
                begin
                    if (kx[s] == r.kx && ky[s] == r.ky && kz[s] == r.kz)
                    begin
                        if (remove)
                        begin
                            if (!f[FL_CARRY] && have_prev)
                                flags[base + prev][FL_CARRY] = 1'b0;
                            flags[s][FL_DEL] = 1'b1;
                        end
                        slot = i;
                        return 1;
                    end
                    if (!f[FL_CARRY])
                        return 0;
                    have_prev = 1;
                    prev = i;
                end
                i = (i + 1) & (size - 1);
                if (i == start)
                    return 0;
                d++;
            end
        endfunction

        function void note_request(request_t r);
            answer_t a;
            int slot;
            int s;
            int b;
            a = '{default: '0};
            slot = 0;
            case (r.cmd)
                CMD_LOOKUP, CMD_STALE:
                begin
                    if (search(r, 0, slot))
                    begin
                        s = bank * TABLE_DEPTH + slot;
                        a.hit = 1'b1;
                        a.slot = 8'(slot);
                        if (r.cmd == CMD_LOOKUP)
                        begin
                            a.rword = word[s];
                            a.rfresh = fresh[s];
                        end
                        else
                            fresh[s] = 1'b0;
                    end
                    else
                        a.status = ST_MISS;
                end
                CMD_INS_CUR, CMD_INS_NEXT:
                begin
                    b = (r.cmd == CMD_INS_NEXT) ? int'(!bank) : int'(bank);
                    if (insert_into(b, r, slot))
                    begin
                        a.hit = 1'b1;
                        a.slot = 8'(slot);
                        if (r.cmd == CMD_INS_NEXT)
                            flags[b * TABLE_DEPTH + slot][FL_STAY] = 1'b1;
                    end
                    else
                        a.status = ST_FULL;
                end
                CMD_REMOVE:
                begin
                    if (search(r, 1, slot))
                    begin
                        a.hit = 1'b1;
                        a.slot = 8'(slot);
                    end
                    else
                        a.status = ST_MISS;
                end
                CMD_ADVANCE:
                begin
                    for (int i = 0; i < slots_in_use(); i++)
                        flags[bank * TABLE_DEPTH + i] = '0;
                    bank = !bank;
                end
                default:
                    ;
            endcase
            pending.push_back(a);
        endfunction

        function void check_answer(answer_t got);
            answer_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit)
            begin
                $error("hit: expected %0h, actual %0h", e.hit, got.hit);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0h, actual %0h", e.status, got.status);
                errors++;
            end
            if (got.slot !== e.slot)
            begin
                $error("slot_index: expected %0h, actual %0h", e.slot, got.slot);
                errors++;
            end
            if (got.rword !== e.rword)
            begin
                $error("read_word: expected %0h, actual %0h", e.rword, got.rword);
                errors++;
            end
            if (got.rfresh !== e.rfresh)
            begin
                $error("read_fresh: expected %0h, actual %0h", e.rfresh, got.rfresh);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         command;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]        payload_word;
    logic               payload_fresh;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic [1:0]         status;
    logic [7:0]         slot_index;
    logic [31:0]        read_word;
    logic               read_fresh;

    hash_table_scoreboard table_model;
    int send_idle_pct;
    int recv_stall_pct;
    int cycle_count;
    request_t known_keys [$];

    double_buffered_probe_hash_table_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .key_x(key_x),
        .key_y(key_y),
        .key_z(key_z),
        .payload_word(payload_word),
        .payload_fresh(payload_fresh),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .status(status),
        .slot_index(slot_index),
        .read_word(read_word),
        .read_fresh(read_fresh)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("double_buffered_probe_hash_table_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            table_model.check_answer('{hit, status, slot_index, read_word, read_fresh});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_request(request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= r.cmd;
        key_x <= r.kx;
        key_y <= r.ky;
        key_z <= r.kz;
        payload_word <= r.word;
        payload_fresh <= r.fresh;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        table_model.note_request(r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (table_model.pending.size() != 0)
            @(posedge clk);
        repeat (600)
            @(posedge clk);
    endtask

    task automatic write_size(logic [3:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_model.size_log2 = v;
    endtask

    function automatic request_t random_request();
        request_t r;
        int pick;
        r.cmd = $urandom_range(99) < 3 ? CMD_ADVANCE : 3'($urandom_range(4));
        if ($urandom_range(99) < 2)
            r.cmd = 3'($urandom_range(7, 6));
        r.kx = $urandom;
        r.ky = $urandom;
        r.kz = $urandom;
        if ($urandom_range(99) < 30)
        begin
            r.kx = $urandom_range(7);
            r.ky = -$urandom_range(3);
            r.kz = $urandom_range(3);
        end
        if (known_keys.size() != 0 && $urandom_range(99) < 60)
        begin
            pick = $urandom_range(known_keys.size() - 1);
            r.kx = known_keys[pick].kx;
            r.ky = known_keys[pick].ky;
            r.kz = known_keys[pick].kz;
        end
        r.word = $urandom;
        r.fresh = $urandom_range(1);
        if (r.cmd == CMD_INS_CUR || r.cmd == CMD_INS_NEXT)
        begin
            known_keys.push_back(r);
            if (known_keys.size() > 40)
                void'(known_keys.pop_front());
        end
        return r;
    endfunction

    initial
    begin
        request_t r;
        logic [3:0] sizes [6];
        table_model = new();
        sizes = '{4'd1, 4'd2, 4'd8, 4'd0, 4'd15, 4'd4};
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 4'd8;
        in_valid = 1'b0;
        out_stall = 1'b0;
        command = CMD_LOOKUP;
        key_x = '0;
        key_y = '0;
        key_z = '0;
        payload_word = '0;
        payload_fresh = 1'b0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request('{CMD_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0});
        send_request('{CMD_INS_CUR, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                       32'hffffffff, 1'b1});
        send_request('{CMD_LOOKUP, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 1'b0});
        send_request('{CMD_INS_CUR, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h5, 1'b0});
        send_request('{CMD_STALE, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 1'b0});
        send_request('{CMD_LOOKUP, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 1'b0});
        send_request('{CMD_INS_NEXT, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1'b1});
        send_request('{CMD_REMOVE, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 1'b0});
        send_request('{CMD_REMOVE, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 1'b0});
        send_request('{3'd6, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1});
        send_request('{3'd7, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1});
        send_request('{CMD_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0});
        send_request('{CMD_LOOKUP, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1'b0});
        drain_results();

        // With two slots, a third key reports a full table and removals reopen slots.
        write_size(4'd1);
        for (int k = 0; k < 4; k++)
            send_request('{CMD_INS_CUR, k, 32'h0, 32'h0, k, 1'b1});
        send_request('{CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0});
        send_request('{CMD_INS_CUR, 32'h3, 32'h0, 32'h0, 32'h9, 1'b0});
        send_request('{CMD_LOOKUP, 32'h3, 32'h0, 32'h0, 32'h0, 1'b0});
        drain_results();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_size(sizes[phase]);
            case (phase % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 80; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 80; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int n = 0; n < 100; n++)
            begin
                r = random_request();
                send_request(r);
            end
            drain_results();
            recv_stall_pct = 0;
        end

        if (table_model.errors == 0)
            $display("double_buffered_probe_hash_table_top regression: pass");
        else
            $display("double_buffered_probe_hash_table_top regression: fail");
        $finish;
    end
endmodule
